// ===== src/pbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared constants, register indexes, status codes and state types for the
// PackBits run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrd_pkg;

   // Default sizes handed to the top level.
   localparam int LENGTH_BITS_DEF = 24;
   localparam int OUT_LANES_DEF   = 4;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODEC_MODE      = 1'b0,
      CSR_EXPECTED_LENGTH = 1'b1
   } csr_index_type;

   // Codec modes.
   localparam logic MODE_RAW = 1'b0;
   localparam logic MODE_RLE = 1'b1;

   // Control byte decoding.
   localparam logic [7:0] REPEAT_FLAG = 8'h80;
   localparam logic [7:0] REPEAT_MASK = 8'h7f;
   localparam logic [7:0] REPEAT_BIAS = 8'd3;
   localparam logic [7:0] LITERAL_BIAS = 8'd1;

   // End-of-stream status codes carried on each result beat.
   typedef enum logic [1:0] {
      END_CONTINUE = 2'd0,
      END_OK       = 2'd1,
      END_FAILED   = 2'd2
   } end_status_type;

   // Stream decode phase.
   typedef enum logic [1:0] {
      PHASE_CONTROL = 2'd0,
      PHASE_LITERAL = 2'd1,
      PHASE_REPEAT  = 2'd2
   } phase_type;

   // Output sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EMIT   = 3'b010,
      ST_STATUS = 3'b100
   } seq_state_type;

endpackage

`default_nettype wire

// ===== src/pbrd_channels.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder channels
// Valid/ready interfaces for the compressed byte input and the packed result
// output of the PackBits run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       source_last;

   modport source (output valid, output source_byte, output source_last, input ready);
   modport sink   (input valid, input source_byte, input source_last, output ready);
endinterface

interface pbrd_rsp_if #(
   parameter int OUT_LANES = pbrd_pkg::OUT_LANES_DEF
);
   localparam int BYTES_W = OUT_LANES * 8;
   localparam int CNT_W   = $clog2(OUT_LANES + 1);

   logic               valid;
   logic               ready;
   logic [BYTES_W-1:0] out_bytes;
   logic [CNT_W-1:0]   byte_count;
   logic [1:0]         end_status;
   logic               run_last;

   modport source (output valid, output out_bytes, output byte_count, output end_status,
                   output run_last, input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input end_status,
                   input run_last, output ready);
endinterface

`default_nettype wire

// ===== src/pbrd_len_unit.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder length unit
// The shared adder and comparator that advances the decoded byte count and
// checks it against the expected stream length.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrd_len_unit #(
   parameter int LENGTH_BITS = pbrd_pkg::LENGTH_BITS_DEF
) (
   input  wire logic [LENGTH_BITS-1:0] produced,
   input  wire logic [7:0]             addend,
   input  wire logic [LENGTH_BITS-1:0] expected,
   output logic      [LENGTH_BITS:0]   sum,
   output logic                        over
);

   // One extra bit keeps the carry so the compare never wraps.
   assign sum  = {1'b0, produced} + (LENGTH_BITS + 1)'(addend);
   assign over = sum > {1'b0, expected};

endmodule

`default_nettype wire

// ===== src/packbits_run_length_decoder.sv =====
// A literal byte or an in-length raw byte shows its result in the cycle after it is accepted.
// A repeat byte emits ceil(n / OUT_LANES) beats, one per unstalled cycle, input held off meanwhile.
// A final byte adds one status beat; control bytes are taken one per cycle while the output is free, with no result.
// Throughput is one byte per unstalled cycle outside repeat runs and status beats, set by the single output register.
// Reset (synchronous, active high) restores codec_mode = 1, expected_length = 0
// and an empty stream, and drops any pending result.
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Decodes a PackBits byte stream or passes raw bytes, packs repeat runs into multi-byte beats and
// reports whether the stream ended with exactly the expected length.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_run_length_decoder #(
   parameter int LENGTH_BITS = pbrd_pkg::LENGTH_BITS_DEF,
   parameter int OUT_LANES   = pbrd_pkg::OUT_LANES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [pbrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [LENGTH_BITS-1:0]           csr_wdata,
   pbrd_req_if.sink                              req_chan,
   pbrd_rsp_if.source                            rsp_chan
);

   localparam int BYTES_W = OUT_LANES * 8;
   localparam int CNT_W   = $clog2(OUT_LANES + 1);
   localparam logic [7:0] LANES8 = 8'(OUT_LANES);

   // Configuration registers.
   logic                   mode_ff;
   logic [LENGTH_BITS-1:0] expected_ff;

   // Stream state.
   pbrd_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]             literal_rem_ff, literal_rem_in;
   logic [7:0]             repeat_len_ff, repeat_len_in;
   logic [LENGTH_BITS-1:0] produced_ff, produced_in;
   logic                   failed_ff, failed_in;

   // Output sequencer.
   pbrd_pkg::seq_state_type state_ff, state_in;
   logic [7:0]              emit_byte_ff, emit_byte_in;
   logic [7:0]              emit_left_ff, emit_left_in;
   logic                    emit_last_ff, emit_last_in;
   logic                    status_ok_ff, status_ok_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTES_W-1:0] out_bytes_ff, out_bytes_in;
   logic [CNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [1:0]         end_status_ff, end_status_in;
   logic               run_last_ff, run_last_in;

   // Intermediate values of one step.
   logic                   out_free;
   logic                   accept;
   logic [7:0]             in_byte;
   logic                   in_last;
   logic                   is_repeat;
   logic [7:0]             ctrl_cnt;
   logic [7:0]             rem_dec;
   logic [7:0]             addend;
   logic [LENGTH_BITS:0]   len_sum;
   logic                   len_over;
   pbrd_pkg::phase_type    phase_step;
   logic [7:0]             literal_rem_step;
   logic [7:0]             repeat_len_step;
   logic [LENGTH_BITS-1:0] produced_step;
   logic                   failed_step;
   logic                   data_load;
   logic                   repeat_start;
   logic                   step_ok;
   logic [7:0]             emit_take;
   logic [7:0]             emit_after;
   logic [BYTES_W-1:0]     emit_word;

   // Handshake.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == pbrd_pkg::ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.source_byte;
   assign in_last        = req_chan.source_last;

   // Control byte decoding.
   assign is_repeat = (in_byte & pbrd_pkg::REPEAT_FLAG) != 8'd0;
   assign ctrl_cnt  = is_repeat ? (in_byte & pbrd_pkg::REPEAT_MASK) + pbrd_pkg::REPEAT_BIAS
                                : in_byte + pbrd_pkg::LITERAL_BIAS;
   assign rem_dec   = (literal_rem_ff == 8'd0) ? 8'd0 : literal_rem_ff - 8'd1;

   // The amount the length unit adds in this step.
   always_comb begin
      if (mode_ff == pbrd_pkg::MODE_RAW) begin
         addend = 8'd1;
      end else begin
         unique case (phase_ff)
            pbrd_pkg::PHASE_LITERAL: addend = 8'd1;
            pbrd_pkg::PHASE_REPEAT:  addend = repeat_len_ff;
            default:                 addend = ctrl_cnt;
         endcase
      end
   end

   pbrd_len_unit #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_len (
      .produced (produced_ff),
      .addend   (addend),
      .expected (expected_ff),
      .sum      (len_sum),
      .over     (len_over)
   );

   // Stream state update for an accepted byte.
   always_comb begin
      phase_step       = phase_ff;
      literal_rem_step = literal_rem_ff;
      repeat_len_step  = repeat_len_ff;
      produced_step    = produced_ff;
      failed_step      = failed_ff;
      data_load        = 1'b0;
      repeat_start     = 1'b0;
      if (!failed_ff) begin
         if (mode_ff == pbrd_pkg::MODE_RAW) begin
            if (len_over) begin
               failed_step = 1'b1;
            end else begin
               data_load     = 1'b1;
               produced_step = len_sum[LENGTH_BITS-1:0];
            end
         end else begin
            unique case (phase_ff)
               pbrd_pkg::PHASE_LITERAL: begin
                  data_load        = 1'b1;
                  produced_step    = len_sum[LENGTH_BITS-1:0];
                  literal_rem_step = rem_dec;
                  if (rem_dec == 8'd0) begin
                     phase_step = pbrd_pkg::PHASE_CONTROL;
                  end
               end
               pbrd_pkg::PHASE_REPEAT: begin
                  repeat_start    = 1'b1;
                  produced_step   = len_sum[LENGTH_BITS-1:0];
                  repeat_len_step = 8'd0;
                  phase_step      = pbrd_pkg::PHASE_CONTROL;
               end
               default: begin
                  if (in_last || len_over) begin
                     failed_step = 1'b1;
                  end else if (is_repeat) begin
                     repeat_len_step = ctrl_cnt;
                     phase_step      = pbrd_pkg::PHASE_REPEAT;
                  end else begin
                     literal_rem_step = ctrl_cnt;
                     phase_step       = pbrd_pkg::PHASE_LITERAL;
                  end
               end
            endcase
         end
      end
      step_ok = !failed_step && (produced_step == expected_ff) &&
                ((mode_ff == pbrd_pkg::MODE_RAW) || (phase_step == pbrd_pkg::PHASE_CONTROL));
   end

   // The end of a stream returns its state to the reset values.
   always_comb begin
      phase_in       = phase_ff;
      literal_rem_in = literal_rem_ff;
      repeat_len_in  = repeat_len_ff;
      produced_in    = produced_ff;
      failed_in      = failed_ff;
      if (accept) begin
         if (in_last) begin
            phase_in       = pbrd_pkg::PHASE_CONTROL;
            literal_rem_in = 8'd0;
            repeat_len_in  = 8'd0;
            produced_in    = '0;
            failed_in      = 1'b0;
         end else begin
            phase_in       = phase_step;
            literal_rem_in = literal_rem_step;
            repeat_len_in  = repeat_len_step;
            produced_in    = produced_step;
            failed_in      = failed_step;
         end
      end
   end

   // Packing of one repeat beat.
   assign emit_take  = (emit_left_ff < LANES8) ? emit_left_ff : LANES8;
   assign emit_after = emit_left_ff - emit_take;

   always_comb begin
      for (int i = 0; i < OUT_LANES; i++) begin
         emit_word[i*8 +: 8] = (8'(i) < emit_take) ? emit_byte_ff : 8'd0;
      end
   end

   // Output sequencer and result register loading.
   always_comb begin
      state_in      = state_ff;
      emit_byte_in  = emit_byte_ff;
      emit_left_in  = emit_left_ff;
      emit_last_in  = emit_last_ff;
      status_ok_in  = status_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_bytes_in  = out_bytes_ff;
      byte_count_in = byte_count_ff;
      end_status_in = end_status_ff;
      run_last_in   = run_last_ff;
      unique case (state_ff)
         pbrd_pkg::ST_IDLE: begin
            if (accept) begin
               status_ok_in = step_ok;
               if (repeat_start) begin
                  state_in     = pbrd_pkg::ST_EMIT;
                  emit_byte_in = in_byte;
                  emit_left_in = repeat_len_ff;
                  emit_last_in = in_last;
               end else if (data_load) begin
                  rsp_valid_in  = 1'b1;
                  out_bytes_in  = BYTES_W'(in_byte);
                  byte_count_in = CNT_W'(1);
                  end_status_in = pbrd_pkg::END_CONTINUE;
                  run_last_in   = !in_last;
                  if (in_last) begin
                     state_in = pbrd_pkg::ST_STATUS;
                  end
               end else if (in_last) begin
                  rsp_valid_in  = 1'b1;
                  out_bytes_in  = '0;
                  byte_count_in = '0;
                  end_status_in = step_ok ? pbrd_pkg::END_OK : pbrd_pkg::END_FAILED;
                  run_last_in   = 1'b1;
               end
            end
         end
         pbrd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_bytes_in  = emit_word;
               byte_count_in = CNT_W'(emit_take);
               end_status_in = pbrd_pkg::END_CONTINUE;
               run_last_in   = (emit_after == 8'd0) && !emit_last_ff;
               emit_left_in  = emit_after;
               if (emit_after == 8'd0) begin
                  state_in = emit_last_ff ? pbrd_pkg::ST_STATUS : pbrd_pkg::ST_IDLE;
               end
            end
         end
         pbrd_pkg::ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_bytes_in  = '0;
               byte_count_in = '0;
               end_status_in = status_ok_ff ? pbrd_pkg::END_OK : pbrd_pkg::END_FAILED;
               run_last_in   = 1'b1;
               state_in      = pbrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbrd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= pbrd_pkg::MODE_RLE;
         expected_ff    <= '0;
         phase_ff       <= pbrd_pkg::PHASE_CONTROL;
         literal_rem_ff <= 8'd0;
         repeat_len_ff  <= 8'd0;
         produced_ff    <= '0;
         failed_ff      <= 1'b0;
         state_ff       <= pbrd_pkg::ST_IDLE;
         emit_left_ff   <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (pbrd_pkg::csr_index_type'(csr_index))
               pbrd_pkg::CSR_CODEC_MODE:      mode_ff     <= csr_wdata[0];
               pbrd_pkg::CSR_EXPECTED_LENGTH: expected_ff <= csr_wdata;
               default:                       mode_ff     <= mode_ff;
            endcase
         end
         phase_ff       <= phase_in;
         literal_rem_ff <= literal_rem_in;
         repeat_len_ff  <= repeat_len_in;
         produced_ff    <= produced_in;
         failed_ff      <= failed_in;
         state_ff       <= state_in;
         emit_left_ff   <= emit_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      emit_byte_ff  <= emit_byte_in;
      emit_last_ff  <= emit_last_in;
      status_ok_ff  <= status_ok_in;
      out_bytes_ff  <= out_bytes_in;
      byte_count_ff <= byte_count_in;
      end_status_ff <= end_status_in;
      run_last_ff   <= run_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_bytes  = out_bytes_ff;
   assign rsp_chan.byte_count = byte_count_ff;
   assign rsp_chan.end_status = end_status_ff;
   assign rsp_chan.run_last   = run_last_ff;

endmodule

`default_nettype wire

// ===== src/pbrd_checker.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder checker
// Concurrent checks on the result port of the PackBits run-length decoder,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrd_checker #(
   parameter int OUT_LANES = pbrd_pkg::OUT_LANES_DEF
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [OUT_LANES*8-1:0]           out_bytes,
   input wire logic [$clog2(OUT_LANES+1)-1:0]   byte_count,
   input wire logic [1:0]                       end_status,
   input wire logic                             run_last
);

   localparam int CNT_W = $clog2(OUT_LANES + 1);

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_bytes) && $stable(byte_count)
         && $stable(end_status) && $stable(run_last))
      else $error("result beat changed while stalled");

   // Reset drops any pending result.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A status-only beat closes its run and carries a final status.
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_count == '0 |-> run_last &&
         (end_status == pbrd_pkg::END_OK || end_status == pbrd_pkg::END_FAILED))
      else $error("status beat malformed");

   // A data beat carries at most one word of lanes and no final status.
   a_data_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_count != '0 |-> end_status == pbrd_pkg::END_CONTINUE &&
         byte_count <= CNT_W'(OUT_LANES))
      else $error("data beat malformed");

endmodule

bind packbits_run_length_decoder pbrd_checker #(
   .OUT_LANES (OUT_LANES)
) u_pbrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_bytes  (rsp_chan.out_bytes),
   .byte_count (rsp_chan.byte_count),
   .end_status (rsp_chan.end_status),
   .run_last   (rsp_chan.run_last)
);

`default_nettype wire

// ===== tb/tb_packbits_run_length_decoder.sv =====
// ----------------------------------------------------------------------------
// PackBits run-length decoder testbench
// Drives compressed and raw byte streams into the decoder. A directed table
// covers the corner cases, and random streams follow: mostly well-formed, some
// truncated, noisy or of the wrong length. Every result beat is compared with
// the output of a local decoder model or a beat typed into the table. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_packbits_run_length_decoder;
   import pbrd_pkg::*;

   localparam int          SETTLE      = 4;
   localparam int          WATCH_LIMIT = 500;
   localparam int          ITEM_TARGET = 400;
   localparam int          CALM_FROM   = 340;
   localparam logic [23:0] LEN_MAX     = 24'hffffff;

   // One result beat as the decoder should present it.
   typedef struct packed {
      logic [31:0]    bytes;
      logic [2:0]     count;
      end_status_type status;
      logic           tail;
   } beat_type;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_MODE,
      ROW_LENGTH
   } row_kind_type;

   // A directed row: a stream byte or a register write. A byte row may carry
   // its single expected beat typed in.
   typedef struct packed {
      row_kind_type kind;
      logic [23:0]  value;
      logic         last;
      logic         typed;
      beat_type     want;
   } stim_row_type;

   localparam int SCRIPT_ROWS = 37;
   localparam stim_row_type SCRIPT [SCRIPT_ROWS] = '{
      // Straight after reset: a lone control byte marked last is truncated.
      '{ROW_BYTE,   24'h00,     1'b1, 1'b1, '{32'h0,        3'd0, END_FAILED,   1'b1}},
      // Shortest repeat run, exactly the expected length.
      '{ROW_LENGTH, 24'd3,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h80,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'hff,     1'b1, 1'b0, '0},
      // Longest repeat run gives the most beats for one byte.
      '{ROW_LENGTH, 24'd130,    1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'hff,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h00,     1'b1, 1'b0, '0},
      // Two literals, then a literal run that overflows the length.
      '{ROW_LENGTH, 24'd2,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h01,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'haa,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h55,     1'b1, 1'b0, '0},
      '{ROW_BYTE,   24'h02,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h34,     1'b1, 1'b1, '{32'h0,        3'd0, END_FAILED,   1'b1}},
      // Stream ends while literal bytes are still owed.
      '{ROW_LENGTH, 24'd4,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h03,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h01,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h02,     1'b1, 1'b0, '0},
      // Raw pass-through, then a raw byte beyond the expected length.
      '{ROW_MODE,   {23'd0, MODE_RAW}, 1'b0, 1'b0, '0},
      '{ROW_LENGTH, 24'd2,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h00,     1'b0, 1'b1, '{32'h0,        3'd1, END_CONTINUE, 1'b1}},
      '{ROW_BYTE,   24'hff,     1'b1, 1'b0, '0},
      '{ROW_LENGTH, 24'd1,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'ha5,     1'b0, 1'b1, '{32'h0000_00a5, 3'd1, END_CONTINUE, 1'b1}},
      '{ROW_BYTE,   24'h5a,     1'b1, 1'b1, '{32'h0,        3'd0, END_FAILED,   1'b1}},
      '{ROW_LENGTH, 24'd0,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h77,     1'b1, 1'b1, '{32'h0,        3'd0, END_FAILED,   1'b1}},
      // Mode switched to raw in the middle of a literal run.
      '{ROW_MODE,   {23'd0, MODE_RLE}, 1'b0, 1'b0, '0},
      '{ROW_LENGTH, 24'd3,      1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h01,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h11,     1'b0, 1'b0, '0},
      '{ROW_MODE,   {23'd0, MODE_RAW}, 1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h22,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h33,     1'b1, 1'b0, '0},
      // Largest expected length: a full-lane beat, then a length mismatch.
      '{ROW_MODE,   {23'd0, MODE_RLE}, 1'b0, 1'b0, '0},
      '{ROW_LENGTH, LEN_MAX,    1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'h81,     1'b0, 1'b0, '0},
      '{ROW_BYTE,   24'hc3,     1'b1, 1'b0, '0}
   };

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [23:0]   csr_wdata;

   pbrd_req_if                              req_if ();
   pbrd_rsp_if #(.OUT_LANES(OUT_LANES_DEF)) rsp_if ();

   packbits_run_length_decoder #(
      .LENGTH_BITS (LENGTH_BITS_DEF),
      .OUT_LANES   (OUT_LANES_DEF)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source)
   );

   // Beats still owed by the decoder, oldest first.
   beat_type owed_beats [$];
   beat_type head_beat;

   int fail_count   = 0;
   int items_sent   = 0;
   int quiet_cycles = 0;
   int ready_hold   = 0;
   bit calm         = 1'b0;
   bit quiet        = 1'b0;
   bit req_live     = 1'b0;

   // Local copy of the registers and of the stream state.
   logic        mode_now;
   logic [23:0] length_now;
   phase_type   step_phase;
   logic [7:0]  lit_owed;
   logic [7:0]  rep_run;
   logic [23:0] out_total;
   bit          broken;

   always #5 clock = ~clock;

   function automatic void clear_stream();
      step_phase = PHASE_CONTROL;
      lit_owed   = '0;
      rep_run    = '0;
      out_total  = '0;
      broken     = 1'b0;
   endfunction

   // Decodes one stream byte and returns the beats it should cause.
   function automatic void decode_byte(input logic [7:0] b, input logic fin,
                                       ref beat_type fresh [$]);
      int          left;
      int          lanes;
      logic [31:0] word;
      logic [31:0] run;
      beat_type    one;
      bit          ok;
      fresh.delete();
      if (!broken) begin
         if (mode_now == MODE_RAW) begin
            if (out_total >= length_now) begin
               broken = 1'b1;
            end else begin
               fresh.insert(fresh.size(), '{{24'd0, b}, 3'd1, END_CONTINUE, 1'b0});
               out_total = out_total + 24'd1;
            end
         end else if (step_phase == PHASE_LITERAL) begin
            fresh.insert(fresh.size(), '{{24'd0, b}, 3'd1, END_CONTINUE, 1'b0});
            out_total = out_total + 24'd1;
            if (lit_owed > 0) lit_owed = lit_owed - 8'd1;
            if (lit_owed == 0) step_phase = PHASE_CONTROL;
         end else if (step_phase == PHASE_REPEAT) begin
            // Pack the repeated byte into full beats, remainder last.
            left = rep_run;
            while (left > 0) begin
               lanes = (left < OUT_LANES_DEF) ? left : OUT_LANES_DEF;
               word  = '0;
               for (int i = 0; i < lanes; i++) word[8*i +: 8] = b;
               one = '{word, 3'(lanes), END_CONTINUE, 1'b0};
               fresh.insert(fresh.size(), one);
               left -= lanes;
            end
            out_total  = out_total + 24'(rep_run);
            rep_run    = '0;
            step_phase = PHASE_CONTROL;
         end else begin
            // Control byte: open a literal or a repeat run if it fits.
            if ((b & REPEAT_FLAG) == 0) run = 32'(b) + 32'(LITERAL_BIAS);
            else run = 32'(b & REPEAT_MASK) + 32'(REPEAT_BIAS);
            if (fin || (32'(out_total) + run > 32'(length_now))) begin
               broken = 1'b1;
            end else if ((b & REPEAT_FLAG) == 0) begin
               lit_owed   = 8'(run);
               step_phase = PHASE_LITERAL;
            end else begin
               rep_run    = 8'(run);
               step_phase = PHASE_REPEAT;
            end
         end
      end
      if (fin) begin
         ok = !broken && (out_total == length_now) &&
              (mode_now == MODE_RAW || step_phase == PHASE_CONTROL ||
               step_phase == 2'd3);
         fresh.insert(fresh.size(), '{32'h0, 3'd0, ok ? END_OK : END_FAILED, 1'b0});
         clear_stream();
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].tail = 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", field, got, want);
      fail_count++;
   endtask

   // Offers one byte, waits for the beat to be taken and records the
   // expected results. A random pause may follow.
   task automatic send_beat(input logic [7:0] b, input logic fin, input logic typed,
                            input beat_type typed_beat);
      beat_type fresh [$];
      req_if.valid       <= 1'b1;
      req_if.source_byte <= b;
      req_if.source_last <= fin;
      req_live = 1'b1;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      decode_byte(b, fin, fresh);
      if (typed) owed_beats.insert(owed_beats.size(), typed_beat);
      else foreach (fresh[k]) owed_beats.insert(owed_beats.size(), fresh[k]);
      items_sent++;
      if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         req_live = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Register write once the decoder has delivered everything it owes.
   task automatic write_csr(input csr_index_type idx, input logic [23:0] value);
      if (req_live) begin
         req_if.valid <= 1'b0;
         req_live = 1'b0;
      end
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_CODEC_MODE) mode_now = value[0];
      else length_now = value;
      csr_wr_en <= 1'b0;
   endtask

   // Result sink: ready drops in random bursts until the calm end of the run.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold   <= ready_hold - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold   <= $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (owed_beats.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_if.out_bytes, 32'h0);
         end else begin
            head_beat = owed_beats.pop_front();
            if (rsp_if.out_bytes !== head_beat.bytes)
               report_mismatch("out_bytes", rsp_if.out_bytes, head_beat.bytes);
            if (rsp_if.byte_count !== head_beat.count)
               report_mismatch("byte_count", 32'(rsp_if.byte_count), 32'(head_beat.count));
            if (rsp_if.end_status !== head_beat.status)
               report_mismatch("end_status", 32'(rsp_if.end_status), 32'(head_beat.status));
            if (rsp_if.run_last !== head_beat.tail)
               report_mismatch("run_last", 32'(rsp_if.run_last), 32'(head_beat.tail));
         end
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [7:0]  stream_q [$];
      logic [23:0] plain_len;
      int          segs;
      int          run;
      int          variant;
      bit          raw_phase;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_CODEC_MODE;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.source_byte = '0;
      req_if.source_last = 1'b0;
      rsp_if.ready       = 1'b0;
      mode_now           = MODE_RLE;
      length_now         = '0;
      clear_stream();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (SCRIPT[i]) begin
         case (SCRIPT[i].kind)
            ROW_BYTE: begin
               send_beat(SCRIPT[i].value[7:0], SCRIPT[i].last, SCRIPT[i].typed,
                         SCRIPT[i].want);
            end
            ROW_MODE: begin
               write_csr(CSR_CODEC_MODE, SCRIPT[i].value);
            end
            default: begin
               write_csr(CSR_EXPECTED_LENGTH, SCRIPT[i].value);
            end
         endcase
      end

      // Random streams, one register setting per stream.
      while (items_sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 3) == 0);
         calm  = (items_sent >= CALM_FROM);
         stream_q.delete();
         plain_len = '0;
         raw_phase = ($urandom_range(0, 4) == 0);
         if (raw_phase) begin
            run = $urandom_range(1, 12);
            repeat (run) stream_q.insert(stream_q.size(), 8'($urandom));
            plain_len = 24'(run);
         end else begin
            // Well-formed stream of literal and repeat runs, mostly short.
            segs = $urandom_range(1, 4);
            repeat (segs) begin
               if ($urandom_range(0, 1) == 0) begin
                  run = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 6);
                  stream_q.insert(stream_q.size(), 8'(run - 1));
                  repeat (run) stream_q.insert(stream_q.size(), 8'($urandom));
               end else begin
                  run = ($urandom_range(0, 9) == 0) ? 130 : $urandom_range(3, 8);
                  stream_q.insert(stream_q.size(), REPEAT_FLAG | 8'(run - 3));
                  stream_q.insert(stream_q.size(), 8'($urandom));
               end
               plain_len = plain_len + 24'(run);
            end
         end

         // Spoil a share of the streams: truncation, noise, wrong length.
         variant = $urandom_range(0, 15);
         case (variant)
            10: begin
               if (stream_q.size() > 1) void'(stream_q.pop_back());
            end
            11: begin
               stream_q.delete();
               repeat ($urandom_range(1, 8)) stream_q.insert(stream_q.size(), 8'($urandom));
            end
            12: plain_len = plain_len + 24'd1;
            13: begin
               if (plain_len > 0) plain_len = plain_len - 24'd1;
            end
            14: plain_len = '0;
            15: plain_len = LEN_MAX;
            default: ;
         endcase

         write_csr(CSR_CODEC_MODE, {23'd0, raw_phase ? MODE_RAW : MODE_RLE});
         write_csr(CSR_EXPECTED_LENGTH, plain_len);
         foreach (stream_q[i])
            send_beat(stream_q[i], i == stream_q.size() - 1, 1'b0, '0);
      end

      // Let the decoder drain, then report.
      if (req_live) begin
         req_if.valid <= 1'b0;
         req_live = 1'b0;
      end
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (4 * SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
